[sv/bdcd_pkg.sv]
// ----------------------------------------------------------------------------
// bdcd_pkg
// Shared constants, codes and helpers for the bounded-distance codebook decoder.
// ----------------------------------------------------------------------------
package bdcd_pkg;

	localparam int WORD_BITS      = 8;
	localparam int CODEBOOK_DEPTH = 1024;
	localparam int ADDR_W         = $clog2(CODEBOOK_DEPTH);
	localparam int CNT_W          = $clog2(CODEBOOK_DEPTH + 1);
	localparam int DIST_W         = 4;

	localparam logic [DIST_W-1:0] NO_PAIR = DIST_W'(WORD_BITS + 1);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [DIST_W-1:0]    dist_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [ADDR_W-1:0]    addr_t;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_DECODE = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	// Hamming distance between two words
	function automatic dist_t bit_distance(input word_t a, input word_t b);
		word_t x;
		dist_t n;
		x = a ^ b;
		n = '0;
		for (int k = 0; k < WORD_BITS; k++) begin
			n = n + DIST_W'(x[k]);
		end
		return n;
	endfunction

	// Correction radius from the minimum distance
	function automatic dist_t radius_of(input dist_t d);
		dist_t r;
		if (d >= NO_PAIR) begin
			r = NO_PAIR;
		end else if (d == '0) begin
			r = '0;
		end else begin
			r = (d - DIST_W'(1)) >> 1;
		end
		return r;
	endfunction

endpackage

[sv/bdcd_if.sv]
// ----------------------------------------------------------------------------
// bdcd_if
// Request and result channels of the codebook decoder (valid/ready).
// ----------------------------------------------------------------------------
interface bdcd_req_if
	import bdcd_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	word_t      word;

	modport source (output valid, output func, output word, input ready);
	modport sink   (input valid, input func, input word, output ready);
endinterface

interface bdcd_rsp_if
	import bdcd_pkg::*;
;
	logic  valid;
	logic  ready;
	logic  found;
	word_t corrected_word;
	dist_t error_bits;
	dist_t code_distance;

	modport source (output valid, output found, output corrected_word,
		output error_bits, output code_distance, input ready);
	modport sink   (input valid, input found, input corrected_word,
		input error_bits, input code_distance, output ready);
endinterface

[sv/bdcd_ram.sv]
// ----------------------------------------------------------------------------
// bdcd_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bdcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/bounded_distance_codebook_decoder.sv]
// ----------------------------------------------------------------------------
// bounded_distance_codebook_decoder
// Codebook of 8-bit words with minimum-distance tracking and bounded decoding.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request per handshake: func (load, decode, clear) and
//   word. rsp_ch carries one result for each decode request only; load, clear
//   and the unused func code give nothing back.
//   Clear acts on acceptance. A load writes the word into the codebook RAM at
//   once and then reads every stored entry, one RAM read a cycle, to update
//   the minimum distance. A decode reads entries in load order and stops at
//   the first one inside the radius. A load into a full codebook is dropped.
//   Only one request is worked on at a time; the single RAM read port sets
//   the rate.
//   Reset empties the codebook (count zero, distance 9); the RAM is not
//   cleared, entries above the count are never read.
//   The result sits in an output register; the next request is taken while
//   it waits. A second decode result waits inside the block until the output
//   register frees up, and no further request is taken meanwhile.
// ----------------------------------------------------------------------------
module bounded_distance_codebook_decoder
	import bdcd_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	bdcd_req_if.sink    req_ch,
	bdcd_rsp_if.source  rsp_ch
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0] state_q;
	logic       is_load_q;
	word_t      word_q;
	dist_t      radius_q;
	cnt_t       count_q;
	cnt_t       idx_q;
	dist_t      min_q;
	logic       rd_s1;

	logic       res_found_q;
	word_t      res_word_q;
	dist_t      res_err_q;

	logic       out_valid_q;
	logic       out_found_q;
	word_t      out_word_q;
	dist_t      out_err_q;
	dist_t      out_dist_q;

	logic       accept;
	logic       full;
	logic       we;
	word_t      rdata;
	dist_t      dist_c;
	logic       hit_c;
	logic       issue_c;
	logic       scan_end_c;
	logic       out_free;

	assign req_ch.ready = (state_q == ST_IDLE);
	assign accept       = req_ch.valid && req_ch.ready;
	assign full         = (count_q == cnt_t'(CODEBOOK_DEPTH));
	assign we           = accept && (req_ch.func == FUNC_LOAD) && !full;

	// Entry at count is written on accept; the scan only reads below it.
	bdcd_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (CODEBOOK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (req_ch.word),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	assign dist_c     = bit_distance(rdata, word_q);
	assign hit_c      = rd_s1 && !is_load_q && (dist_c <= radius_q);
	assign issue_c    = (state_q == ST_SCAN) && (idx_q < count_q) && !hit_c;
	assign scan_end_c = (state_q == ST_SCAN) && (idx_q >= count_q) && !rd_s1;
	assign out_free   = !out_valid_q || rsp_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			min_q       <= NO_PAIR;
			idx_q       <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= issue_c;
			if (issue_c) begin
				idx_q <= idx_q + cnt_t'(1);
			end

			if (state_q == ST_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						priority if (req_ch.func == FUNC_CLEAR) begin
							count_q <= '0;
							min_q   <= NO_PAIR;
						end else if (req_ch.func == FUNC_DECODE) begin
							state_q <= ST_SCAN;
						end else if (req_ch.func == FUNC_LOAD && !full) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_s1 && is_load_q && dist_c < min_q) begin
						min_q <= dist_c;
					end
					if (hit_c || (scan_end_c && !is_load_q)) begin
						state_q <= ST_HOLD;
					end else if (scan_end_c) begin
						count_q <= count_q + cnt_t'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			is_load_q   <= (req_ch.func == FUNC_LOAD);
			word_q      <= req_ch.word;
			radius_q    <= radius_of(min_q);
			res_found_q <= 1'b0;
			res_word_q  <= '0;
			res_err_q   <= '0;
		end
		if (hit_c) begin
			res_found_q <= 1'b1;
			res_word_q  <= rdata;
			res_err_q   <= dist_c;
		end
		if (state_q == ST_HOLD && out_free) begin
			out_found_q <= res_found_q;
			out_word_q  <= res_word_q;
			out_err_q   <= res_err_q;
			out_dist_q  <= min_q;
		end
	end

	assign rsp_ch.valid          = out_valid_q;
	assign rsp_ch.found          = out_found_q;
	assign rsp_ch.corrected_word = out_word_q;
	assign rsp_ch.error_bits     = out_err_q;
	assign rsp_ch.code_distance  = out_dist_q;

endmodule

[sv/bdcd_checker.sv]
// ----------------------------------------------------------------------------
// bdcd_checker
// Port-level checks on the codebook decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bdcd_checker
	import bdcd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [1:0] req_func,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_found,
	input word_t      rsp_corrected_word,
	input dist_t      rsp_error_bits,
	input dist_t      rsp_code_distance
);

	// a result is held until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before it was taken");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_corrected_word == '0 && rsp_error_bits == '0)
		else $error("not-found result carries a word or error count");

	// matched word lies inside the correction radius
	a_within_radius: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found && rsp_code_distance != NO_PAIR |->
		(rsp_code_distance == '0 && rsp_error_bits == '0) ||
		((DIST_W+1)'(rsp_error_bits) << 1) < (DIST_W+1)'(rsp_code_distance))
		else $error("match outside correction radius");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_code_distance <= NO_PAIR && rsp_error_bits <= DIST_W'(WORD_BITS))
		else $error("distance out of range");

	// ready is low in the cycle after a decode request is taken
	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == FUNC_DECODE |=> !req_ready)
		else $error("request taken while decode in progress");

endmodule

bind bounded_distance_codebook_decoder bdcd_checker u_bdcd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req_ch.valid),
	.req_ready          (req_ch.ready),
	.req_func           (req_ch.func),
	.rsp_valid          (rsp_ch.valid),
	.rsp_ready          (rsp_ch.ready),
	.rsp_found          (rsp_ch.found),
	.rsp_corrected_word (rsp_ch.corrected_word),
	.rsp_error_bits     (rsp_ch.error_bits),
	.rsp_code_distance  (rsp_ch.code_distance)
);

[bench/tb_bounded_distance_codebook_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_distance_codebook_decoder
// Drives load, decode, clear and unused requests into the codebook decoder.
// A scoreboard keeps its own codebook, entry count and minimum distance, and
// checks each decode result in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_bounded_distance_codebook_decoder;
	import bdcd_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS   = 520;
	// slowest request is a full scan of the codebook plus stalls
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 1100;

	typedef struct packed {
		logic  found;
		word_t corrected_word;
		dist_t error_bits;
		dist_t code_distance;
	} decode_result_t;

	class codebook_tracker;
		word_t          entries[CODEBOOK_DEPTH];
		int             entry_count;
		dist_t          min_distance;
		decode_result_t expected_decodes[$];
		int             mismatches;

		function new();
			entry_count  = 0;
			min_distance = NO_PAIR;
			mismatches   = 0;
		endfunction

		function int pending();
			return expected_decodes.size();
		endfunction

		function void note_request(logic [1:0] func, word_t word);
			decode_result_t r;
			int             radius;
			int             d;
			case (func)
				FUNC_LOAD: begin
					// a full codebook drops the load, distance untouched
					if (entry_count < CODEBOOK_DEPTH) begin
						for (int i = 0; i < entry_count; i++) begin
							d = $countones(entries[i] ^ word);
							if (d < int'(min_distance))
								min_distance = dist_t'(d);
						end
						entries[entry_count] = word;
						entry_count++;
					end
				end
				FUNC_CLEAR: begin
					entry_count  = 0;
					min_distance = NO_PAIR;
				end
				FUNC_DECODE: begin
					if (min_distance >= NO_PAIR)
						radius = WORD_BITS + 1;
					else if (min_distance == '0)
						radius = 0;
					else
						radius = (int'(min_distance) - 1) / 2;
					r = '0;
					r.code_distance = min_distance;
					for (int i = 0; i < entry_count; i++) begin
						d = $countones(entries[i] ^ word);
						if (d <= radius) begin
							r.found          = 1'b1;
							r.corrected_word = entries[i];
							r.error_bits     = dist_t'(d);
							break;
						end
					end
					expected_decodes.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_decode(decode_result_t got);
			decode_result_t want;
			if (expected_decodes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no decode outstanding: found=%0d word=%02h",
						$time, got.found, got.corrected_word);
				return;
			end
			want = expected_decodes.pop_front();
			if (got.found !== want.found || got.corrected_word !== want.corrected_word ||
					got.error_bits !== want.error_bits ||
					got.code_distance !== want.code_distance) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: decode mismatch: exp found=%0d word=%02h err=%0d dist=%0d",
						$time, want.found, want.corrected_word, want.error_bits,
						want.code_distance, "  got found=%0d word=%02h err=%0d dist=%0d",
						got.found, got.corrected_word, got.error_bits, got.code_distance);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bdcd_req_if req_ch();
	bdcd_rsp_if rsp_ch();

	bounded_distance_codebook_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_ch),
		.rsp_ch (rsp_ch)
	);

	codebook_tracker tracker = new();

	bit send_idle;
	bit recv_idle;
	int requests_sent;
	int idle_cycles;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// one request per call; valid stays high into the next call
	task automatic send_request(input logic [1:0] func, input word_t word);
		int   gap;
		logic hit;
		if (send_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func  <= func;
		req_ch.word  <= word;
		do begin
			@(negedge clk);
			hit = req_ch.ready;
			@(posedge clk);
		end while (hit !== 1'b1);
		tracker.note_request(func, word);
		if (func != FUNC_UNUSED)
			requests_sent++;
	endtask

	// build a small code with a chosen spacing, then decode near its words
	task automatic run_code_phase();
		word_t loaded[$];
		word_t cand;
		word_t rx;
		word_t mask;
		int    n;
		int    min_sep;
		int    decodes;
		int    flips;
		int    tries;
		bit    ok;
		if ($urandom_range(0, 4) != 0)
			send_request(FUNC_CLEAR, word_t'($urandom));
		min_sep = $urandom_range(1, 6);
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
		for (int i = 0; i < n; i++) begin
			if (loaded.size() != 0 && $urandom_range(0, 11) == 0) begin
				cand = loaded[$urandom_range(0, loaded.size() - 1)];
			end else begin
				tries = 0;
				do begin
					cand = word_t'($urandom);
					ok   = 1'b1;
					foreach (loaded[j])
						if ($countones(cand ^ loaded[j]) < min_sep)
							ok = 1'b0;
					tries++;
				end while (!ok && tries < 16);
			end
			loaded.push_back(cand);
			send_request(FUNC_LOAD, cand);
			if ($urandom_range(0, 19) == 0)
				send_request(FUNC_UNUSED, word_t'($urandom));
		end
		decodes = $urandom_range(1, 10);
		for (int i = 0; i < decodes; i++) begin
			if (loaded.size() == 0 || $urandom_range(0, 5) == 0) begin
				rx = word_t'($urandom);
			end else begin
				rx    = loaded[$urandom_range(0, loaded.size() - 1)];
				flips = $urandom_range(0, 4);
				mask  = '0;
				while ($countones(mask) < flips)
					mask[$urandom_range(0, WORD_BITS - 1)] = 1'b1;
				rx = rx ^ mask;
			end
			send_request(FUNC_DECODE, rx);
			if ($urandom_range(0, 15) == 0)
				send_request(FUNC_LOAD, word_t'($urandom));
		end
	endtask

	// result side: random stall bursts while recv_idle is set
	initial begin
		decode_result_t got;
		logic           take;
		int             stall_left;
		stall_left   = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			take = rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1;
			got.found          = rsp_ch.found;
			got.corrected_word = rsp_ch.corrected_word;
			got.error_bits     = rsp_ch.error_bits;
			got.code_distance  = rsp_ch.code_distance;
			@(posedge clk);
			if (take)
				tracker.check_decode(got);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (recv_idle && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n !== 1'b1) begin
			idle_cycles = 0;
		end else if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int random_start;
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.func  <= FUNC_LOAD;
		req_ch.word  <= '0;
		send_idle     = 1'b1;
		recv_idle     = 1'b1;
		requests_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty codebook, then the unused code
		send_request(FUNC_DECODE, 8'h3C);
		send_request(FUNC_UNUSED, 8'hFF);
		// single entry: unlimited radius
		send_request(FUNC_LOAD, 8'h00);
		send_request(FUNC_DECODE, 8'hFF);
		// distance 8, radius 3
		send_request(FUNC_LOAD, 8'hFF);
		send_request(FUNC_DECODE, 8'h07);
		send_request(FUNC_DECODE, 8'h0F);
		send_request(FUNC_DECODE, 8'hFE);
		send_request(FUNC_DECODE, 8'hFF);
		// distance 4, radius 1
		send_request(FUNC_LOAD, 8'h0F);
		send_request(FUNC_DECODE, 8'h01);
		send_request(FUNC_DECODE, 8'h03);
		// duplicate: exact match only
		send_request(FUNC_LOAD, 8'h0F);
		send_request(FUNC_DECODE, 8'h0F);
		send_request(FUNC_DECODE, 8'h0E);
		send_request(FUNC_CLEAR, 8'hAA);
		send_request(FUNC_DECODE, 8'h55);
		send_request(FUNC_LOAD, 8'hA5);
		send_request(FUNC_DECODE, 8'h5A);
		send_request(FUNC_CLEAR, 8'h00);

		random_start = requests_sent;
		while (requests_sent - random_start < RANDOM_ITEMS) begin
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			run_code_phase();
		end

		// last part without idling
		send_idle = 1'b0;
		recv_idle = 1'b0;
		repeat (3) run_code_phase();
		req_ch.valid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
sv/bdcd_pkg.sv
sv/bdcd_if.sv
sv/bdcd_ram.sv
sv/bounded_distance_codebook_decoder.sv
sv/bdcd_checker.sv
bench/tb_bounded_distance_codebook_decoder.sv
